// ===== hw/rtl/fcgi_rd_pkg.sv =====
`default_nettype none
package fcgi_rd_pkg;

  // record types
  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;
  localparam logic [7:0] TYPE_STDERR      = 8'd7;

  // byte tags
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_STDOUT  = 3'd1;
  localparam logic [2:0] KIND_STDERR  = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_PADDING = 3'd4;
  localparam logic [2:0] KIND_SKIPPED = 3'd5;

  // header byte positions
  localparam logic [2:0] HDR_VERSION  = 3'd0;
  localparam logic [2:0] HDR_TYPE     = 3'd1;
  localparam logic [2:0] HDR_LEN_HI   = 3'd4;
  localparam logic [2:0] HDR_LEN_LO   = 3'd5;
  localparam logic [2:0] HDR_PAD_LEN  = 3'd6;
  localparam logic [2:0] HDR_RESERVED = 3'd7;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_kind;
    logic       record_last;
    logic       request_done;
    logic [7:0] current_type;
  } result_t;

  function automatic logic [2:0] content_tag(input logic [7:0] rtype);
    logic [2:0] tag;
    case (rtype)
      TYPE_STDOUT:      tag = KIND_STDOUT;
      TYPE_STDERR:      tag = KIND_STDERR;
      TYPE_END_REQUEST: tag = KIND_END;
      default:          tag = KIND_SKIPPED;
    endcase
    return tag;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fcgi_rd_tracker.sv =====
`default_nettype none
// Record parse state; tags one byte per step.
module fcgi_rd_tracker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data,
  output fcgi_rd_pkg::result_t   res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CONTENT = 2'd1;
  localparam logic [1:0] PH_PADDING = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] content_left, content_left_next;
  logic [7:0]  padding_left, padding_left_next;
  logic [2:0]  kind;
  logic        last;

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    record_kind_next  = record_kind;
    length_high_next  = length_high;
    content_left_next = content_left;
    padding_left_next = padding_left;
    last              = 1'b0;
    kind              = fcgi_rd_pkg::KIND_HEADER;
    unique case (phase)
      PH_CONTENT: begin
        kind              = fcgi_rd_pkg::content_tag(record_kind);
        content_left_next = content_left - 16'd1;
        if (content_left_next == 16'd0) begin
          if (padding_left != 8'd0) begin
            phase_next = PH_PADDING;
          end else begin
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end
      end
      PH_PADDING: begin
        kind              = fcgi_rd_pkg::KIND_PADDING;
        padding_left_next = padding_left - 8'd1;
        if (padding_left_next == 8'd0) begin
          last       = 1'b1;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // header phase; unused code 3 behaves the same
        case (header_index)
          fcgi_rd_pkg::HDR_VERSION: record_kind_next  = 8'd0;
          fcgi_rd_pkg::HDR_TYPE:    record_kind_next  = data;
          fcgi_rd_pkg::HDR_LEN_HI:  length_high_next  = data;
          fcgi_rd_pkg::HDR_LEN_LO:  content_left_next = {length_high, data};
          fcgi_rd_pkg::HDR_PAD_LEN: padding_left_next = data;
          default: ;
        endcase
        if (header_index == fcgi_rd_pkg::HDR_RESERVED) begin
          header_index_next = 3'd0;
          if (content_left != 16'd0) begin
            phase_next = PH_CONTENT;
          end else if (padding_left != 8'd0) begin
            phase_next = PH_PADDING;
          end else begin
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end else begin
          header_index_next = header_index + 3'd1;
          phase_next        = PH_HEADER;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_out     = data;
    res.byte_kind    = kind;
    res.record_last  = last;
    res.current_type = record_kind_next;
    res.request_done = last && (record_kind_next == fcgi_rd_pkg::TYPE_END_REQUEST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= 3'd0;
      record_kind  <= 8'd0;
      length_high  <= 8'd0;
      content_left <= 16'd0;
      padding_left <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      record_kind  <= record_kind_next;
      length_high  <= length_high_next;
      content_left <= content_left_next;
      padding_left <= padding_left_next;
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    step && res.request_done |-> res.record_last)
    else $error("request_done without record_last");

  a_last_back_to_header: assert property (@(posedge clk) disable iff (rst)
    step && res.record_last |=> phase == PH_HEADER && header_index == 3'd0)
    else $error("record end did not return to header start");

  a_header_index_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> header_index == 3'd0)
    else $error("header index moved outside header phase");

  a_padding_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PADDING |-> padding_left != 8'd0)
    else $error("padding phase with nothing left");

endmodule
`default_nettype wire

// ===== hw/rtl/fcgi_rd_outreg.sv =====
`default_nettype none
// Result register on the master side.
module fcgi_rd_outreg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire fcgi_rd_pkg::result_t res,
  input  wire logic              ready,
  output logic                   valid,
  output fcgi_rd_pkg::result_t   held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fastcgi_record_deframer.sv =====
`default_nettype none
// A slave byte is captured in the input register, then tagged and loaded into the result
// register that drives m_tvalid; a stall on m_tready holds it in the input register.
// Throughput: one byte per cycle while m_tready stays high; tracker state advances once per
// byte moved to the result register, with no other stall inside the block.
// Reset: synchronous rst clears both stage valids and returns the parser to the start of
// a record header; no clearing pass.
module fastcgi_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] byte_out, [15:8] current_type
  output logic             m_tlast,   // record_last
  output logic [3:0]       m_tuser    // [2:0] byte_kind, [3] request_done
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 step;
  fcgi_rd_pkg::result_t res;
  fcgi_rd_pkg::result_t held;

  // A byte moves on when the result register is empty or being drained.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Header capture, length counting and byte tagging.
  fcgi_rd_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (in_byte),
    .res  (res)
  );

  fcgi_rd_outreg u_outreg (
    .clk   (clk),
    .rst   (rst),
    .load  (step),
    .res   (res),
    .ready (m_tready),
    .valid (m_tvalid),
    .held  (held)
  );

  assign m_tdata = {held.current_type, held.byte_out};
  assign m_tlast = held.record_last;
  assign m_tuser = {held.request_done, held.byte_kind};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are full");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("result lost after step");

  a_kind_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:0] <= fcgi_rd_pkg::KIND_SKIPPED)
    else $error("byte kind out of range");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Parser position of the scoreboard copy; the block never uses a fourth code.
  typedef enum logic [1:0] {
    AT_HEADER  = 2'd0,
    IN_CONTENT = 2'd1,
    IN_PADDING = 2'd2
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;     // [7:0] stream_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;             // [7:0] byte_out, [15:8] current_type
  logic        m_tlast;             // record_last
  logic [3:0]  m_tuser;             // [2:0] byte_kind, [3] request_done

  // Scoreboard copy of the record tracker.
  parse_phase_t phase_q  = AT_HEADER;
  logic [2:0]   hdr_pos  = fcgi_rd_pkg::HDR_VERSION;
  logic [7:0]   rec_type = 8'h00;
  logic [7:0]   len_hi   = 8'h00;
  logic [15:0]  content_cnt = 16'h0000;
  logic [7:0]   pad_cnt  = 8'h00;

  fcgi_rd_pkg::result_t tagged_bytes[$];  // tags still owed by the block, oldest first
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  bit          steady = 1'b0;       // when set, neither side inserts gaps

  fastcgi_record_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the tracker by one accepted byte and queue the tag it must get.
  task automatic track_byte(input logic [7:0] b);
    fcgi_rd_pkg::result_t tag;
    tag = '0;
    tag.byte_out = b;
    case (phase_q)
      IN_CONTENT: begin
        case (rec_type)
          fcgi_rd_pkg::TYPE_STDOUT:      tag.byte_kind = fcgi_rd_pkg::KIND_STDOUT;
          fcgi_rd_pkg::TYPE_STDERR:      tag.byte_kind = fcgi_rd_pkg::KIND_STDERR;
          fcgi_rd_pkg::TYPE_END_REQUEST: tag.byte_kind = fcgi_rd_pkg::KIND_END;
          default:                       tag.byte_kind = fcgi_rd_pkg::KIND_SKIPPED;
        endcase
        content_cnt = content_cnt - 16'd1;
        if (content_cnt == 16'd0) begin
          if (pad_cnt != 8'd0) begin
            phase_q = IN_PADDING;
          end else begin
            tag.record_last = 1'b1;
            phase_q = AT_HEADER;
          end
        end
      end
      IN_PADDING: begin
        tag.byte_kind = fcgi_rd_pkg::KIND_PADDING;
        pad_cnt = pad_cnt - 8'd1;
        if (pad_cnt == 8'd0) begin
          tag.record_last = 1'b1;
          phase_q = AT_HEADER;
        end
      end
      default: begin
        tag.byte_kind = fcgi_rd_pkg::KIND_HEADER;
        // type is unknown on the version byte, so it reads as zero there
        case (hdr_pos)
          fcgi_rd_pkg::HDR_VERSION: rec_type = 8'h00;
          fcgi_rd_pkg::HDR_TYPE:    rec_type = b;
          fcgi_rd_pkg::HDR_LEN_HI:  len_hi = b;
          fcgi_rd_pkg::HDR_LEN_LO:  content_cnt = {len_hi, b};
          fcgi_rd_pkg::HDR_PAD_LEN: pad_cnt = b;
          default: ;
        endcase
        if (hdr_pos == fcgi_rd_pkg::HDR_RESERVED) begin
          hdr_pos = fcgi_rd_pkg::HDR_VERSION;
          if (content_cnt != 16'd0) begin
            phase_q = IN_CONTENT;
          end else if (pad_cnt != 8'd0) begin
            phase_q = IN_PADDING;
          end else begin
            // empty record ends on its last header byte
            tag.record_last = 1'b1;
            phase_q = AT_HEADER;
          end
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
    endcase
    tag.current_type = rec_type;
    tag.request_done = tag.record_last && (rec_type == fcgi_rd_pkg::TYPE_END_REQUEST);
    tagged_bytes.push_back(tag);
  endtask

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_byte();
    fcgi_rd_pkg::result_t want;
    if (tagged_bytes.size() == 0) begin
      $error("byte_out: no transfer expected, got %0d", m_tdata[7:0]);
      fail_count++;
    end else begin
      want = tagged_bytes.pop_front();
      compare_field("byte_out",     32'(want.byte_out),     32'(m_tdata[7:0]));
      compare_field("current_type", 32'(want.current_type), 32'(m_tdata[15:8]));
      compare_field("byte_kind",    32'(want.byte_kind),    32'(m_tuser[2:0]));
      compare_field("request_done", 32'(want.request_done), 32'(m_tuser[3]));
      compare_field("record_last",  32'(want.record_last),  32'(m_tlast));
    end
  endtask

  // Output side: check every transfer, then pick the next tready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_byte();
    end
    m_tready <= steady || ($urandom_range(99) >= 6);
  end

  // One byte on the input side; gaps come before tvalid rises, never mid-transfer.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_byte(b);
    sent_count++;
  endtask

  task automatic send_record(input logic [7:0] rtype, input logic [15:0] len,
                             input logic [7:0] pad, input logic [7:0] version,
                             input logic [15:0] req_id, input logic [7:0] reserved);
    send_byte(version);
    send_byte(rtype);
    send_byte(req_id[15:8]);
    send_byte(req_id[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(pad);
    send_byte(reserved);
    repeat (len) send_byte(8'($urandom_range(255)));
    repeat (pad) send_byte(8'($urandom_range(255)));
  endtask

  // Empty END_REQUEST with all-ones header fields, stdout with padding,
  // then an unknown type whose content must be skipped and consumed.
  task automatic test_directed_records();
    send_record(fcgi_rd_pkg::TYPE_END_REQUEST, 16'd0, 8'd0, 8'hFF, 16'hFFFF, 8'hFF);
    send_record(fcgi_rd_pkg::TYPE_STDOUT, 16'd1, 8'd1, 8'h00, 16'h0000, 8'h00);
    send_record(8'hFF, 16'd1, 8'd0, 8'h01, 16'h0001, 8'h00);
  endtask

  // Well-formed records with random content. Mostly short, now and then a
  // long content or padding run. Includes a gap-free stretch and one drain.
  task automatic test_random_records();
    int unsigned goal;
    int unsigned pick;
    int unsigned steady_end;
    bit          steady_done;
    bit          drained;
    logic [7:0]  rtype;
    logic [15:0] len;
    logic [7:0]  pad;
    goal = sent_count + 1800;
    drained = 1'b0;
    steady_done = 1'b0;
    steady_end = 0;
    while (sent_count < goal) begin
      // gap-free stretch of at least 300 bytes, kept across record borders
      if (!steady_done && sent_count + 1200 >= goal) begin
        steady_done = 1'b1;
        steady = 1'b1;
        steady_end = sent_count + 300;
      end
      if (steady && sent_count >= steady_end) begin
        steady = 1'b0;
      end
      if (!drained && sent_count + 600 >= goal) begin
        // hold the input until every owed tag has been seen
        s_tvalid <= 1'b0;
        while (tagged_bytes.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(9);
      if (pick < 3) rtype = fcgi_rd_pkg::TYPE_STDOUT;
      else if (pick < 5) rtype = fcgi_rd_pkg::TYPE_STDERR;
      else if (pick < 7) rtype = fcgi_rd_pkg::TYPE_END_REQUEST;
      else rtype = 8'($urandom_range(255));
      len = ($urandom_range(19) == 0) ? 16'($urandom_range(600, 256))
                                      : 16'($urandom_range(20));
      pad = ($urandom_range(19) == 0) ? 8'($urandom_range(255, 8))
                                      : 8'($urandom_range(7));
      send_record(rtype, len, pad, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
    end
    steady = 1'b0;
    if (!drained) begin
      // a long last record skipped the drain point; pause here instead
      s_tvalid <= 1'b0;
      while (tagged_bytes.size() != 0) @(posedge clk);
    end
  endtask

  // Arbitrary bytes at the tail: headers with any length, broken records.
  task automatic test_noise_bytes();
    repeat (200) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_records();
    test_random_records();
    test_noise_bytes();
    s_tvalid <= 1'b0;
    while (tagged_bytes.size() != 0) @(posedge clk);
    // two-stage pipe: waiting on past the drain catches any stray transfer
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fastcgi_record_deframer] OK");
    end else begin
      $display("[fastcgi_record_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("[fastcgi_record_deframer] ERROR");
    $finish;
  end

endmodule
